/* src/wrlp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wrlp_pkg
// Types and constants shared by the wrap/replicate line padder.
// ----------------------------------------------------------------------------
package wrlp_pkg;

    localparam int MAX_WIDTH   = 4096;
    localparam int ADDR_W      = $clog2(MAX_WIDTH);
    localparam int SAMPLE_BITS = 32;

    localparam int WIDTH_W  = 13;
    localparam int COUNT_W  = 16;
    localparam int POS_W    = 14;
    localparam int REPEAT_W = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // func codes
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_EMIT = 1'b1;

    // status codes
    localparam logic [1:0] ST_SAMPLE  = 2'd0;
    localparam logic [1:0] ST_LOADED  = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;
    localparam logic [1:0] ST_REFUSED = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_PAD   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_PAD  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_PAD    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_PAD = 3'd5;

    typedef struct packed {
        logic                   func;
        logic [SAMPLE_BITS-1:0] sample_in;
    } req_item_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample_out;
        logic [1:0]             status;
        logic                   end_of_line;
        logic                   end_of_image;
    } res_item_t;

endpackage : wrlp_pkg
`default_nettype wire

/* src/wrlp_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wrlp_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module wrlp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule : wrlp_ram
`default_nettype wire

/* src/wrap_replicate_line_padder_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wrap_replicate_line_padder_core
// Line padder: horizontal wrap-around, vertical edge-line replication.
// ----------------------------------------------------------------------------
// One request is taken every cycle while the result side keeps up; each result
// passes the stage-one register, with the registered line-store read, and the
// result register. Loads write one sample into the line store, emits read one
// padded sample back with end-of-line and end-of-image marks. Loads are
// refused while the held line still has output to give. The user must write
// configuration through cfg_write only while no request is in flight; the
// block does not enforce this. The line store needs no clearing after reset.
// ----------------------------------------------------------------------------
module wrap_replicate_line_padder_core (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_write,
    input  wire logic [wrlp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [wrlp_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                               req_valid,
    output logic                                    req_ready,
    input  wire wrlp_pkg::req_item_t                req_data,
    output logic                                    res_valid,
    input  wire logic                               res_ready,
    output wrlp_pkg::res_item_t                     res_data
);

    localparam int WW = wrlp_pkg::WIDTH_W;
    localparam int CW = wrlp_pkg::COUNT_W;
    localparam int PW = wrlp_pkg::POS_W;
    localparam int RW = wrlp_pkg::REPEAT_W;
    localparam int AW = wrlp_pkg::ADDR_W;

    // configuration
    logic [WW-1:0] line_width_reg, left_pad_reg, right_pad_reg;
    logic [CW-1:0] line_count_reg, top_pad_reg, bottom_pad_reg;

    // line state
    logic [WW-1:0] fill_count_reg, fill_count_next;
    logic          line_ready_reg, line_ready_next;
    logic [PW-1:0] out_pos_reg, out_pos_next;
    logic [RW-1:0] repeats_reg, repeats_next;
    logic [CW-1:0] line_num_reg, line_num_next;

    // pipeline
    logic                s1_valid_reg;
    wrlp_pkg::res_item_t s1_item_reg, s1_item_next;
    logic                res_valid_reg;
    wrlp_pkg::res_item_t res_item_reg, res_item_next;

    logic                         advance, req_fire;
    logic [wrlp_pkg::SAMPLE_BITS-1:0] ram_q;
    logic                         ram_wr, ram_rd;
    logic [AW-1:0]                rd_addr;

    // derived geometry
    logic [WW-1:0] w, lp, rp, fill_inc;
    logic [CW-1:0] used_count;
    logic          is_last;
    logic [PW-1:0] total, pos, pos_off, pos_inc, idx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= WW'(wrlp_pkg::MAX_WIDTH);
            line_count_reg <= CW'(1);
            left_pad_reg   <= '0;
            right_pad_reg  <= '0;
            top_pad_reg    <= '0;
            bottom_pad_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                wrlp_pkg::REG_LINE_WIDTH: line_width_reg <= cfg_data[WW-1:0];
                wrlp_pkg::REG_LINE_COUNT: line_count_reg <= cfg_data;
                wrlp_pkg::REG_LEFT_PAD:   left_pad_reg   <= cfg_data[WW-1:0];
                wrlp_pkg::REG_RIGHT_PAD:  right_pad_reg  <= cfg_data[WW-1:0];
                wrlp_pkg::REG_TOP_PAD:    top_pad_reg    <= cfg_data;
                wrlp_pkg::REG_BOTTOM_PAD: bottom_pad_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign advance   = !res_valid_reg || res_ready;
    assign req_ready = !s1_valid_reg || advance;
    assign req_fire  = req_valid && req_ready;

    always_comb
    begin
        if (line_width_reg == '0)
            w = WW'(1);
        else if (line_width_reg > WW'(wrlp_pkg::MAX_WIDTH))
            w = WW'(wrlp_pkg::MAX_WIDTH);
        else
            w = line_width_reg;
        lp = (left_pad_reg > w) ? w : left_pad_reg;
        rp = (right_pad_reg > w) ? w : right_pad_reg;
        total = PW'(w) + PW'(lp) + PW'(rp);
        used_count = (line_count_reg == '0) ? CW'(1) : line_count_reg;
        is_last = ({1'b0, line_num_reg} + 17'd1) >= {1'b0, used_count};
        fill_inc = fill_count_reg + WW'(1);

        pos = (out_pos_reg >= total) ? total - PW'(1) : out_pos_reg;
        pos_off = pos - PW'(lp);
        if (pos < PW'(lp))
            idx = pos + PW'(w) - PW'(lp);
        else if (pos_off < PW'(w))
            idx = pos_off;
        else
            idx = pos_off - PW'(w);
        pos_inc = pos + PW'(1);
    end

    always_comb
    begin
        fill_count_next = fill_count_reg;
        line_ready_next = line_ready_reg;
        out_pos_next    = out_pos_reg;
        repeats_next    = repeats_reg;
        line_num_next   = line_num_reg;
        s1_item_next    = '{sample_out: '0, status: wrlp_pkg::ST_EMPTY,
                            end_of_line: 1'b0, end_of_image: 1'b0};
        ram_wr          = 1'b0;
        ram_rd          = 1'b0;

        if (req_data.func == wrlp_pkg::FUNC_LOAD)
        begin
            if (line_ready_reg)
            begin
                s1_item_next.status = wrlp_pkg::ST_REFUSED;
            end
            else
            begin
                ram_wr = req_fire;
                s1_item_next.status = wrlp_pkg::ST_LOADED;
                fill_count_next = fill_inc;
                if (fill_inc >= w)
                begin
                    fill_count_next = '0;
                    line_ready_next = 1'b1;
                    out_pos_next    = '0;
                    repeats_next    = RW'(1)
                        + ((line_num_reg == '0) ? RW'(top_pad_reg) : '0)
                        + (is_last ? RW'(bottom_pad_reg) : '0);
                end
            end
        end
        else if (line_ready_reg)
        begin
            ram_rd = req_fire;
            s1_item_next.status = wrlp_pkg::ST_SAMPLE;
            out_pos_next = pos_inc;
            if (pos_inc >= total)
            begin
                s1_item_next.end_of_line = 1'b1;
                out_pos_next = '0;
                if (repeats_reg > RW'(1) )
                begin
                    repeats_next = repeats_reg - RW'(1);
                end
                else
                begin
                    repeats_next    = '0;
                    line_ready_next = 1'b0;
                    if (is_last)
                    begin
                        s1_item_next.end_of_image = 1'b1;
                        line_num_next = '0;
                    end
                    else
                    begin
                        line_num_next = line_num_reg + CW'(1);
                    end
                end
            end
        end
    end

    assign rd_addr = idx[AW-1:0];

    wrlp_ram #(
        .WIDTH (wrlp_pkg::SAMPLE_BITS),
        .DEPTH (wrlp_pkg::MAX_WIDTH)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (ram_wr),
        .wr_addr (fill_count_reg[AW-1:0]),
        .wr_data (req_data.sample_in),
        .rd_en   (ram_rd),
        .rd_addr (rd_addr),
        .rd_data (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg <= '0;
            line_ready_reg <= 1'b0;
            out_pos_reg    <= '0;
            repeats_reg    <= '0;
            line_num_reg   <= '0;
            s1_valid_reg   <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (req_fire)
            begin
                fill_count_reg <= fill_count_next;
                line_ready_reg <= line_ready_next;
                out_pos_reg    <= out_pos_next;
                repeats_reg    <= repeats_next;
                line_num_reg   <= line_num_next;
            end
            if (req_ready)
            begin
                s1_valid_reg <= req_valid;
            end
            if (advance)
            begin
                res_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_comb
    begin
        res_item_next = s1_item_reg;
        if (s1_item_reg.status == wrlp_pkg::ST_SAMPLE)
        begin
            res_item_next.sample_out = ram_q;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            s1_item_reg <= s1_item_next;
        end
        if (advance && s1_valid_reg)
        begin
            res_item_reg <= res_item_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_item_reg;

    // checks
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg < WW'(wrlp_pkg::MAX_WIDTH))
        else $error("fill count beyond line store");

    a_refused_holds: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire && req_data.func == wrlp_pkg::FUNC_LOAD && line_ready_reg
        |=> $stable(fill_count_reg) && line_ready_reg)
        else $error("refused load altered line state");

    a_eoi_eol: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.end_of_image |-> res_data.end_of_line)
        else $error("end of image without end of line");

    a_no_sample_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.status != wrlp_pkg::ST_SAMPLE
        |-> res_data.sample_out == '0 && !res_data.end_of_line)
        else $error("non-sample result carries data");

endmodule : wrap_replicate_line_padder_core
`default_nettype wire
